// ===== rtl/rgbfb_pkg.sv =====
// Shared types and constants for the RGB frame buffer with set, add and fade.
`default_nettype none

package rgbfb_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned PIX_W       = 3 * CHAN_W;
   localparam int unsigned PROD_W      = 2 * CHAN_W;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DIV_STEPS   = CHAN_W;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [1:0] {
      FN_SET  = 2'd0,
      FN_ADD  = 2'd1,
      FN_FADE = 2'd2,
      FN_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_RANGE    = 2'd1,
      ST_ZERO_DIV = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_SET,
      OP_ADD,
      OP_FADE,
      OP_REPORT
   } op_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ADD_WR,
      BK_FD_RD,
      BK_FD_MUL,
      BK_FD_LOAD,
      BK_FD_DIV,
      BK_FD_WR
   } back_state_type;

   typedef struct packed {
      op_type            op;
      status_type        status;
      logic [ADDR_W-1:0] addr;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] fade_mul;
      logic [CHAN_W-1:0] fade_div;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/rgbfb_front.sv =====
// Front end: accept request beats, check coordinates and divisor, build queue commands.
`default_nettype none

module rgbfb_front
   import rgbfb_pkg::*;
#(
   parameter int unsigned ROWS    = 16,
   parameter int unsigned COLUMNS = 64
) (
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_fade_mul,
   input  logic [7:0]  req_fade_div,
   input  logic        q_full,
   input  logic        clearing,
   output logic        push,
   output cmd_type     push_cmd
);

   logic in_range;

   always_comb begin
      in_range  = (req_column < 8'(COLUMNS)) && (req_row < 8'(ROWS));
      req_ready = !q_full && !clearing;
      push      = req_valid && req_ready;

      push_cmd.addr     = ADDR_W'(16'(req_row) * 16'(COLUMNS)) + ADDR_W'(req_column);
      push_cmd.red      = req_red;
      push_cmd.green    = req_green;
      push_cmd.blue     = req_blue;
      push_cmd.fade_mul = req_fade_mul;
      push_cmd.fade_div = req_fade_div;
      push_cmd.op       = OP_REPORT;
      push_cmd.status   = ST_DONE;

      unique case (func_type'(req_func))
         FN_SET: begin
            if (in_range) begin
               push_cmd.op = OP_SET;
            end else begin
               push_cmd.status = ST_RANGE;
            end
         end
         FN_ADD: begin
            if (in_range) begin
               push_cmd.op = OP_ADD;
            end else begin
               push_cmd.status = ST_RANGE;
            end
         end
         FN_FADE: begin
            if (req_fade_div != 8'd0) begin
               push_cmd.op = OP_FADE;
            end else begin
               push_cmd.status = ST_ZERO_DIV;
            end
         end
         FN_NOP: begin
            push_cmd.op = OP_REPORT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/rgbfb_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module rgbfb_queue
   import rgbfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      head  = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rgbfb_back.sv =====
// Back end: pixel memory, clearing pass, read-modify-write, fade sweep and result register.
`default_nettype none

module rgbfb_back
   import rgbfb_pkg::*;
#(
   parameter int unsigned ROWS    = 16,
   parameter int unsigned COLUMNS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  cmd_type     q_head,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_new_red,
   output logic [7:0]  rsp_new_green,
   output logic [7:0]  rsp_new_blue
);

   localparam int unsigned PIXELS = ROWS * COLUMNS;
   localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int unsigned STEP_W = $clog2(DIV_STEPS);
   localparam logic [AW-1:0]     LAST_PIX  = AW'(PIXELS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
   endfunction

   logic [PIX_W-1:0] pixel_mem [PIXELS];

   back_state_type    state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [STEP_W-1:0] step_ff, step_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PIX_W-1:0]  rd_data_ff;
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [CHAN_W-1:0] rem_ff [3];
   logic [CHAN_W-1:0] rem_in [3];
   logic [CHAN_W-1:0] quo_ff [3];
   logic [CHAN_W-1:0] quo_in [3];
   logic [2:0]        sat_ff, sat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [PIX_W-1:0]  rsp_pix_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   logic [PIX_W-1:0]  mem_wdata;

   logic              respond;
   status_type        resp_status;
   logic [PIX_W-1:0]  resp_pix;
   logic [CHAN_W:0]   rem_wide;

   always_comb begin
      state_in    = state_ff;
      sweep_in    = sweep_ff;
      step_in     = step_ff;
      cmd_in      = cmd_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      sat_in      = sat_ff;
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = sweep_ff;
      mem_raddr   = sweep_ff;
      mem_wdata   = '0;
      respond     = 1'b0;
      resp_status = ST_DONE;
      resp_pix    = '0;
      rem_wide    = '0;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_ff == LAST_PIX) begin
               sweep_in = '0;
               state_in = BK_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         BK_IDLE: begin
            mem_raddr = q_head.addr[AW-1:0];
            if (!q_empty && (!rsp_valid_ff || rsp_ready)) begin
               pop    = 1'b1;
               cmd_in = q_head;
               unique case (q_head.op)
                  OP_SET: begin
                     mem_we    = 1'b1;
                     mem_waddr = q_head.addr[AW-1:0];
                     mem_wdata = {q_head.red, q_head.green, q_head.blue};
                     respond   = 1'b1;
                     resp_pix  = {q_head.red, q_head.green, q_head.blue};
                  end
                  OP_ADD: begin
                     state_in = BK_ADD_WR;
                  end
                  OP_FADE: begin
                     sweep_in = '0;
                     state_in = BK_FD_RD;
                  end
                  OP_REPORT: begin
                     respond     = 1'b1;
                     resp_status = q_head.status;
                  end
               endcase
            end
         end
         BK_ADD_WR: begin
            resp_pix  = {sat_add(rd_data_ff[23:16], cmd_ff.red),
                         sat_add(rd_data_ff[15:8], cmd_ff.green),
                         sat_add(rd_data_ff[7:0], cmd_ff.blue)};
            mem_we    = 1'b1;
            mem_waddr = cmd_ff.addr[AW-1:0];
            mem_wdata = resp_pix;
            respond   = 1'b1;
            state_in  = BK_IDLE;
         end
         BK_FD_RD: begin
            state_in = BK_FD_MUL;
         end
         BK_FD_MUL: begin
            for (int i = 0; i < 3; i++) begin
               prod_in[i] = PROD_W'(rd_data_ff[PIX_W-1-CHAN_W*i -: CHAN_W])
                            * PROD_W'(cmd_ff.fade_mul);
            end
            state_in = BK_FD_LOAD;
         end
         BK_FD_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               sat_in[i] = (prod_ff[i] >= {cmd_ff.fade_div, 8'h00});
               rem_in[i] = prod_ff[i][PROD_W-1:CHAN_W];
               quo_in[i] = prod_ff[i][CHAN_W-1:0];
            end
            step_in  = '0;
            state_in = BK_FD_DIV;
         end
         BK_FD_DIV: begin
            for (int i = 0; i < 3; i++) begin
               rem_wide = {rem_ff[i], quo_ff[i][CHAN_W-1]};
               if (rem_wide >= {1'b0, cmd_ff.fade_div}) begin
                  rem_in[i] = CHAN_W'(rem_wide - {1'b0, cmd_ff.fade_div});
                  quo_in[i] = {quo_ff[i][CHAN_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = rem_wide[CHAN_W-1:0];
                  quo_in[i] = {quo_ff[i][CHAN_W-2:0], 1'b0};
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in = BK_FD_WR;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         BK_FD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {sat_ff[0] ? CHAN_MAX : quo_ff[0],
                         sat_ff[1] ? CHAN_MAX : quo_ff[1],
                         sat_ff[2] ? CHAN_MAX : quo_ff[2]};
            if (sweep_ff == LAST_PIX) begin
               sweep_in = '0;
               respond  = 1'b1;
               state_in = BK_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
               state_in = BK_FD_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = respond || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         sweep_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
      if (respond) begin
         rsp_status_ff <= resp_status;
         rsp_pix_ff    <= resp_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pixel_mem[mem_raddr];
   end

   assign clearing      = (state_ff == BK_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_red   = rsp_pix_ff[23:16];
   assign rsp_new_green = rsp_pix_ff[15:8];
   assign rsp_new_blue  = rsp_pix_ff[7:0];

endmodule

`default_nettype wire

// ===== rtl/rgb_frame_buffer_set_add_fade.sv =====
// Top level of the RGB frame buffer with set, saturating add and whole-store fade.
//
//   channel   direction  handshake            beat
//   req_      in         req_valid/req_ready  func, column, row, red, green, blue, fade_mul/div
//   rsp_      out        rsp_valid/rsp_ready  status, new_red, new_green, new_blue
//
// A request beat is registered in the command queue before the back end can take it.
// Set and rejected commands finish in the pop state; add reads memory when popped, then writes.
// Fade pops, then walks every pixel in turn: read, multiply, load, 8 divide steps of the
// bit-serial divider, then write through the write port.
// After reset a clearing pass over every pixel holds req_ready low.
// The back end takes the next command while the result register is free or being drained.
`default_nettype none

module rgb_frame_buffer_set_add_fade
   import rgbfb_pkg::*;
#(
   parameter int unsigned ROWS    = 16,
   parameter int unsigned COLUMNS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_column,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_fade_mul,
   input  logic [7:0]  req_fade_div,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_new_red,
   output logic [7:0]  rsp_new_green,
   output logic [7:0]  rsp_new_blue
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   cmd_type q_head;
   logic    clearing;

   rgbfb_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_column   (req_column),
      .req_row      (req_row),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_fade_mul (req_fade_mul),
      .req_fade_div (req_fade_div),
      .q_full       (q_full),
      .clearing     (clearing),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   rgbfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   rgbfb_back #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_new_red   (rsp_new_red),
      .rsp_new_green (rsp_new_green),
      .rsp_new_blue  (rsp_new_blue)
   );

endmodule

`default_nettype wire

// ===== rtl/rgbfb_checker.sv =====
// Port-level checks for the RGB frame buffer and the bind that attaches them.
`default_nettype none

module rgbfb_checker
   import rgbfb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_new_red,
   input logic [7:0]  rsp_new_green,
   input logic [7:0]  rsp_new_blue
);

   // Hold a stalled result beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_new_red) && $stable(rsp_new_green) && $stable(rsp_new_blue))
      else $error("stalled result beat changed");

   // Drop valid only after a taken beat.
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result beat withdrawn");

   // Rejected commands report no pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |->
         rsp_new_red == 8'd0 && rsp_new_green == 8'd0 && rsp_new_blue == 8'd0)
      else $error("rejected command carries pixel data");

   // Reset starts the clearing pass with no result pending.
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result right after reset");

endmodule

bind rgb_frame_buffer_set_add_fade rgbfb_checker u_rgbfb_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the RGB frame buffer: set, saturating add and fade commands.
`default_nettype none

module testbench;
   import rgbfb_pkg::*;

   localparam int unsigned ROWS         = 16;
   localparam int unsigned COLUMNS      = 64;
   localparam int unsigned NPIX         = ROWS * COLUMNS;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned FADE_BUDGET  = 14;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;

   typedef struct {
      status_type        status;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_rsp_type;

   class frame_store_model;
      logic [PIX_W-1:0] pixels [NPIX];
      pixel_rsp_type    awaited_rsp [$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
         foreach (pixels[i]) pixels[i] = '0;
      endfunction

      function logic [CHAN_W-1:0] sat_sum(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
         logic [CHAN_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[CHAN_W] ? CHAN_MAX : s[CHAN_W-1:0];
      endfunction

      function logic [CHAN_W-1:0] fade_chan(logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] mul,
                                            logic [CHAN_W-1:0] div);
         logic [PROD_W-1:0] quot;
         quot = (PROD_W'(c) * PROD_W'(mul)) / PROD_W'(div);
         return (quot > PROD_W'(CHAN_MAX)) ? CHAN_MAX : quot[CHAN_W-1:0];
      endfunction

      function void take_cmd(logic [1:0] func, logic [7:0] col, logic [7:0] row,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] mul, logic [7:0] div);
         pixel_rsp_type    beat;
         int unsigned      idx;
         logic [PIX_W-1:0] pix;
         beat = '{ST_DONE, 8'd0, 8'd0, 8'd0};
         case (func)
            FN_SET, FN_ADD: begin
               if (col >= COLUMNS || row >= ROWS) begin
                  beat.status = ST_RANGE;
               end else begin
                  idx = int'(row) * COLUMNS + int'(col);
                  pix = pixels[idx];
                  if (func == FN_SET) begin
                     pix = {r, g, b};
                  end else begin
                     pix = {sat_sum(pix[23:16], r), sat_sum(pix[15:8], g), sat_sum(pix[7:0], b)};
                  end
                  pixels[idx] = pix;
                  beat.red   = pix[23:16];
                  beat.green = pix[15:8];
                  beat.blue  = pix[7:0];
               end
            end
            FN_FADE: begin
               if (div == 8'd0) begin
                  beat.status = ST_ZERO_DIV;
               end else begin
                  foreach (pixels[i]) begin
                     pixels[i] = {fade_chan(pixels[i][23:16], mul, div),
                                  fade_chan(pixels[i][15:8], mul, div),
                                  fade_chan(pixels[i][7:0], mul, div)};
                  end
               end
            end
            default: begin
            end
         endcase
         awaited_rsp.push_back(beat);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_rsp(logic [1:0] status, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         pixel_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d rgb %0d %0d %0d",
                     $time, status, r, g, b);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", 32'(want.status), 32'(status));
         compare_field("new_red", 32'(want.red), 32'(r));
         compare_field("new_green", 32'(want.green), 32'(g));
         compare_field("new_blue", 32'(want.blue), 32'(b));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = 2'd0;
   logic [7:0] req_column = 8'd0;
   logic [7:0] req_row = 8'd0;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic [7:0] req_fade_mul = 8'd0;
   logic [7:0] req_fade_div = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_new_red;
   logic [7:0] rsp_new_green;
   logic [7:0] rsp_new_blue;

   bit          allow_idle = 1'b1;
   int unsigned cycle_count = 0;

   frame_store_model store_model = new();

   rgb_frame_buffer_set_add_fade #(
      .ROWS(ROWS),
      .COLUMNS(COLUMNS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_column(req_column),
      .req_row(req_row),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_fade_mul(req_fade_mul),
      .req_fade_div(req_fade_div),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_new_red(rsp_new_red),
      .rsp_new_green(rsp_new_green),
      .rsp_new_blue(rsp_new_blue)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !allow_idle || ($urandom_range(0, 99) >= 32);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            store_model.take_cmd(req_func, req_column, req_row, req_red, req_green, req_blue,
                                 req_fade_mul, req_fade_div);
         end
         if (rsp_valid && rsp_ready) begin
            store_model.check_rsp(rsp_status, rsp_new_red, rsp_new_green, rsp_new_blue);
         end
      end
   end

   task automatic drive_cmd(input logic [1:0] func, input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] mul, input logic [7:0] div);
      while (allow_idle && $urandom_range(0, 99) < 32) begin
         req_valid    <= 1'b0;
         req_func     <= 2'($urandom);
         req_column   <= 8'($urandom);
         req_row      <= 8'($urandom);
         req_red      <= 8'($urandom);
         req_green    <= 8'($urandom);
         req_blue     <= 8'($urandom);
         req_fade_mul <= 8'($urandom);
         req_fade_div <= 8'($urandom);
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_column   <= col;
      req_row      <= row;
      req_red      <= r;
      req_green    <= g;
      req_blue     <= b;
      req_fade_mul <= mul;
      req_fade_div <= div;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned pick;
      int unsigned fades_left;
      logic [1:0]  func;
      logic [7:0]  col, row, r, g, b, mul, div;

      fades_left = FADE_BUDGET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drive_cmd(FN_SET, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'hAA, 8'h55, 8'h01, 8'hFF, 8'hFF);
      drive_cmd(FN_ADD, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'd2, 8'd0, 8'h80, 8'h7F, 8'h01, 8'd0, 8'd0);
      drive_cmd(FN_ADD, 8'd2, 8'd0, 8'h80, 8'h80, 8'hFE, 8'hFF, 8'h00);
      drive_cmd(FN_ADD, 8'd5, 8'd3, 8'd10, 8'd20, 8'd30, 8'd0, 8'd0);
      drive_cmd(FN_ADD, 8'(COLUMNS - 1), 8'(ROWS - 1), 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'(COLUMNS), 8'd0, 8'h11, 8'h22, 8'h33, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'd0, 8'(ROWS), 8'h11, 8'h22, 8'h33, 8'd0, 8'd0);
      drive_cmd(FN_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drive_cmd(FN_ADD, 8'd0, 8'hFF, 8'h01, 8'h01, 8'h01, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'hFF, 8'd0, 8'h01, 8'h01, 8'h01, 8'd0, 8'd0);
      drive_cmd(FN_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drive_cmd(FN_NOP, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      drive_cmd(FN_FADE, 8'd3, 8'd1, 8'd9, 8'd9, 8'd9, 8'hFF, 8'd0);
      drive_cmd(FN_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd1);
      drive_cmd(FN_ADD, 8'd5, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      drive_cmd(FN_SET, 8'd7, 8'd7, 8'hC8, 8'h64, 8'h03, 8'd0, 8'd0);
      drive_cmd(FN_FADE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd128, 8'hFF);
      drive_cmd(FN_ADD, 8'd7, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      drive_cmd(FN_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7);
      drive_cmd(FN_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         allow_idle = !(n >= 250 && n < 400);
         pick = $urandom_range(0, 99);
         r    = 8'($urandom);
         g    = 8'($urandom);
         b    = 8'($urandom);
         mul  = 8'($urandom);
         div  = 8'($urandom);
         if ($urandom_range(0, 1) == 1) begin
            col = 8'($urandom_range(0, 3));
            row = 8'($urandom_range(0, 1));
         end else begin
            col = 8'($urandom_range(0, COLUMNS - 1));
            row = 8'($urandom_range(0, ROWS - 1));
         end
         if (pick < 45) begin
            func = FN_SET;
         end else if (pick < 82) begin
            func = FN_ADD;
         end else if (pick < 89) begin
            func = ($urandom_range(0, 1) == 1) ? FN_ADD : FN_SET;
            if ($urandom_range(0, 1) == 1) begin
               col = 8'($urandom_range(COLUMNS, 255));
               row = 8'($urandom);
            end else begin
               col = 8'($urandom);
               row = 8'($urandom_range(ROWS, 255));
            end
         end else if (pick < 93) begin
            func = FN_NOP;
            col  = 8'($urandom);
            row  = 8'($urandom);
         end else if (pick < 96) begin
            func = FN_FADE;
            div  = 8'd0;
         end else if (fades_left > 0) begin
            func = FN_FADE;
            div  = 8'($urandom_range(1, 255));
            fades_left--;
         end else begin
            func = FN_ADD;
         end
         drive_cmd(func, col, row, r, g, b, mul, div);
      end

      req_valid  <= 1'b0;
      allow_idle = 1'b1;
      while (store_model.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (store_model.mismatches == 0 && store_model.awaited_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
